>>> rtl/rtmx_pkg.sv
`default_nettype none
package rtmx_pkg;

   localparam int NUM_REGS    = 32;
   localparam int STACK_DEPTH = 16;
   localparam int PROG_DEPTH  = 1024;
   localparam int DATA_WIDTH  = 32;

   localparam int REG_W   = $clog2(NUM_REGS);
   localparam int SP_W    = $clog2(STACK_DEPTH);
   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int PC_W    = 11;
   localparam int TGT_W   = 10;
   localparam int CNT_W   = $clog2(DATA_WIDTH + 1);

   typedef enum logic [4:0] {
      OP_MOV  = 5'd0,
      OP_INC  = 5'd1,
      OP_DEC  = 5'd2,
      OP_JMP  = 5'd3,
      OP_JE   = 5'd4,
      OP_JNE  = 5'd5,
      OP_JG   = 5'd6,
      OP_JL   = 5'd7,
      OP_JGE  = 5'd8,
      OP_JLE  = 5'd9,
      OP_ADD  = 5'd10,
      OP_SUB  = 5'd11,
      OP_MUL  = 5'd12,
      OP_DIV  = 5'd13,
      OP_CMP  = 5'd14,
      OP_CALL = 5'd15,
      OP_RET  = 5'd16,
      OP_END  = 5'd17,
      OP_MSG  = 5'd18
   } op_type;

   typedef enum logic [2:0] {
      ST_RUNNING   = 3'd0,
      ST_ENDED     = 3'd1,
      ST_UNWRITTEN = 3'd2,
      ST_BAD_OP    = 3'd3,
      ST_UNDERFLOW = 3'd4,
      ST_OVERFLOW  = 3'd5,
      ST_DIV_ZERO  = 3'd6,
      ST_OFF_END   = 3'd7
   } status_type;

   typedef struct packed {
      logic [4:0]        action;
      logic [4:0]        first_reg;
      logic              first_is_imm;
      logic signed [31:0] first_imm;
      logic [4:0]        second_reg;
      logic              second_is_imm;
      logic signed [31:0] second_imm;
      logic [9:0]        jump_target;
   } req_type;

   typedef struct packed {
      logic [10:0]        next_pc;
      logic [2:0]         status;
      logic               msg_valid;
      logic signed [31:0] msg_value;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic                  is_div;
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
   } md_req_type;

   typedef struct packed {
      logic                  done;
      logic [DATA_WIDTH-1:0] result;
   } md_rsp_type;

endpackage
`default_nettype wire

>>> rtl/rtmx_regfile.sv
`default_nettype none
module rtmx_regfile (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [rtmx_pkg::REG_W-1:0]     wr_addr,
   input  wire logic [rtmx_pkg::DATA_WIDTH-1:0] wr_data,
   input  wire logic                           rd_en,
   input  wire logic [rtmx_pkg::REG_W-1:0]     rd_addr_a,
   input  wire logic [rtmx_pkg::REG_W-1:0]     rd_addr_b,
   output logic [rtmx_pkg::DATA_WIDTH-1:0]     rd_data_a,
   output logic [rtmx_pkg::DATA_WIDTH-1:0]     rd_data_b
);
   import rtmx_pkg::*;

   logic [DATA_WIDTH-1:0] mem [NUM_REGS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end
endmodule
`default_nettype wire

>>> rtl/rtmx_stack.sv
`default_nettype none
module rtmx_stack (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [rtmx_pkg::SP_W-1:0]   wr_addr,
   input  wire logic [rtmx_pkg::PC_W-1:0]   wr_data,
   input  wire logic                        rd_en,
   input  wire logic [rtmx_pkg::SP_W-1:0]   rd_addr,
   output logic [rtmx_pkg::PC_W-1:0]        rd_data
);
   import rtmx_pkg::*;

   // return addresses can be one past the last instruction, hence full pc width
   logic [PC_W-1:0] mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> rtl/rtmx_muldiv.sv
`default_nettype none
module rtmx_muldiv (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rtmx_pkg::md_req_type    md_req,
   output rtmx_pkg::md_rsp_type         md_rsp
);
   import rtmx_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  neg_ff, neg_in;
   logic [DATA_WIDTH:0]   rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] dvs_ff, dvs_in;
   logic [DATA_WIDTH-1:0] res_ff, res_in;

   logic [DATA_WIDTH-1:0]   product;
   logic [DATA_WIDTH-1:0]   mag_a, mag_b;
   logic [DATA_WIDTH:0]     rem_shift, trial;

   always_comb begin
      product = md_req.a * md_req.b;
      mag_a   = md_req.a[DATA_WIDTH-1] ? (~md_req.a + 1'b1) : md_req.a;
      mag_b   = md_req.b[DATA_WIDTH-1] ? (~md_req.b + 1'b1) : md_req.b;
      rem_shift = {rem_ff[DATA_WIDTH-1:0], quo_ff[DATA_WIDTH-1]};
      trial     = rem_shift - {1'b0, dvs_ff};

      busy_in  = busy_ff;
      done_in  = done_ff;
      count_in = count_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      res_in   = res_ff;

      if (md_req.start) begin
         done_in = 1'b0;
         if (md_req.is_div) begin
            busy_in  = 1'b1;
            count_in = CNT_W'(DATA_WIDTH);
            neg_in   = md_req.a[DATA_WIDTH-1] ^ md_req.b[DATA_WIDTH-1];
            rem_in   = '0;
            quo_in   = mag_a;
            dvs_in   = mag_b;
         end else begin
            done_in = 1'b1;
            res_in  = product;
         end
      end else if (busy_ff) begin
         // restoring division, one quotient bit a cycle
         if (!trial[DATA_WIDTH]) begin
            rem_in = trial;
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? (~quo_in + 1'b1) : quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      res_ff <= res_in;
   end

   assign md_rsp.done   = done_ff;
   assign md_rsp.result = res_ff;
endmodule
`default_nettype wire

>>> rtl/toy_register_machine_execute_unit.sv
// channel   ports                          moves
// req       req_valid/req_stall/req_data   one decoded instruction
// rsp       rsp_valid/rsp_stall/rsp_data   next pc, status, message
// csr       csr_write/csr_wdata            program length
//
// An instruction goes through accept, register and stack memory read, then execute.
// mul and div then wait in a further state for the multiplier or the bit-serial divider.
// Synchronous reset clears pc, flags, written bits, stack depth, halt and rsp_valid.
// The result sits in an output register; a stalled rsp holds back only the commit
// of the following instruction, not its acceptance.
`default_nettype none
module toy_register_machine_execute_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rtmx_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rtmx_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [10:0]       csr_wdata
);
   import rtmx_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_WAIT} state_type;

   state_type             state_ff;
   req_type               req_ff;
   logic [PC_W-1:0]       pc_ff, len_ff;
   logic [2:0]            halt_ff;
   logic                  eq_ff, lt_ff, gt_ff;
   logic [DEPTH_W-1:0]    depth_ff;
   logic [NUM_REGS-1:0]   written_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [DATA_WIDTH-1:0] rd_a, rd_b;
   logic [PC_W-1:0]       stk_rd;
   md_req_type            md_req;
   md_rsp_type            md_rsp;

   logic [PC_W-1:0]       limit, pc_inc, nxt, fin_pc;
   logic [2:0]            err, fin_st;
   logic                  ok1, ok2, slot_free, exec_md;
   logic [DATA_WIDTH-1:0] op_a, op_b, wr_val;
   logic                  wr_en, fin_wr, push, pop, set_flags, mv, commit;
   logic [DATA_WIDTH-1:0] fin_val;

   rtmx_regfile u_regfile (
      .clock     (clock),
      .wr_en     (fin_wr),
      .wr_addr   (REG_W'(req_ff.first_reg)),
      .wr_data   (fin_val),
      .rd_en     (state_ff == S_READ),
      .rd_addr_a (REG_W'(req_ff.first_reg)),
      .rd_addr_b (REG_W'(req_ff.second_reg)),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   rtmx_stack u_stack (
      .clock   (clock),
      .wr_en   (commit && push),
      .wr_addr (SP_W'(depth_ff)),
      .wr_data (pc_inc),
      .rd_en   (state_ff == S_READ),
      .rd_addr (SP_W'(depth_ff - 1'b1)),
      .rd_data (stk_rd)
   );

   rtmx_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   always_comb begin
      limit     = (len_ff < PC_W'(PROG_DEPTH)) ? len_ff : PC_W'(PROG_DEPTH);
      pc_inc    = pc_ff + 1'b1;
      slot_free = !rsp_valid_ff || !rsp_stall;
      ok1 = written_ff[REG_W'(req_ff.first_reg)];
      ok2 = req_ff.second_is_imm || written_ff[REG_W'(req_ff.second_reg)];
      op_a = rd_a;
      op_b = req_ff.second_is_imm ? DATA_WIDTH'(req_ff.second_imm) : rd_b;

      err       = ST_RUNNING;
      nxt       = pc_inc;
      wr_en     = 1'b0;
      wr_val    = op_b;
      push      = 1'b0;
      pop       = 1'b0;
      set_flags = 1'b0;
      mv        = 1'b0;
      unique case (req_ff.action)
         OP_MOV: begin
            if (!ok2) err = ST_UNWRITTEN;
            else wr_en = 1'b1;
         end
         OP_INC, OP_DEC: begin
            wr_val = (req_ff.action == OP_INC) ? op_a + 1'b1 : op_a - 1'b1;
            if (!ok1) err = ST_UNWRITTEN;
            else wr_en = 1'b1;
         end
         OP_JMP: nxt = PC_W'(req_ff.jump_target);
         OP_JE:  if (eq_ff) nxt = PC_W'(req_ff.jump_target);
         OP_JNE: if (!eq_ff) nxt = PC_W'(req_ff.jump_target);
         OP_JG:  if (gt_ff) nxt = PC_W'(req_ff.jump_target);
         OP_JL:  if (lt_ff) nxt = PC_W'(req_ff.jump_target);
         OP_JGE: if (gt_ff || eq_ff) nxt = PC_W'(req_ff.jump_target);
         OP_JLE: if (lt_ff || eq_ff) nxt = PC_W'(req_ff.jump_target);
         OP_ADD, OP_SUB: begin
            wr_val = (req_ff.action == OP_ADD) ? op_a + op_b : op_a - op_b;
            if (!ok1 || !ok2) err = ST_UNWRITTEN;
            else wr_en = 1'b1;
         end
         OP_MUL: if (!ok1 || !ok2) err = ST_UNWRITTEN;
         OP_DIV: begin
            if (!ok1 || !ok2) err = ST_UNWRITTEN;
            else if (op_b == '0) err = ST_DIV_ZERO;
         end
         OP_CMP: begin
            if (req_ff.first_is_imm) op_a = DATA_WIDTH'(req_ff.first_imm);
            if (!(req_ff.first_is_imm || ok1) || !ok2) err = ST_UNWRITTEN;
            else set_flags = 1'b1;
         end
         OP_CALL: begin
            if (depth_ff >= DEPTH_W'(STACK_DEPTH)) err = ST_OVERFLOW;
            else begin
               push = 1'b1;
               nxt  = PC_W'(req_ff.jump_target);
            end
         end
         OP_RET: begin
            if (depth_ff == '0) err = ST_UNDERFLOW;
            else begin
               pop = 1'b1;
               nxt = stk_rd;
            end
         end
         OP_END: err = ST_ENDED;
         OP_MSG: begin
            if (req_ff.first_is_imm) op_a = DATA_WIDTH'(req_ff.first_imm);
            if (!(req_ff.first_is_imm || ok1)) err = ST_UNWRITTEN;
            else mv = 1'b1;
         end
         default: err = ST_BAD_OP;
      endcase

      if (halt_ff != ST_RUNNING) begin
         err = halt_ff;
      end else if (pc_ff >= limit) begin
         err = ST_OFF_END;
      end

      exec_md = (err == ST_RUNNING) &&
                (req_ff.action == OP_MUL || req_ff.action == OP_DIV);
      if (state_ff == S_WAIT) begin
         err = ST_RUNNING;
         nxt = pc_inc;
      end

      md_req.start  = (state_ff == S_EXEC) && exec_md;
      md_req.is_div = (req_ff.action == OP_DIV);
      md_req.a      = op_a;
      md_req.b      = op_b;

      commit = slot_free &&
               (((state_ff == S_EXEC) && !exec_md) || ((state_ff == S_WAIT) && md_rsp.done));
      fin_val = (state_ff == S_WAIT) ? md_rsp.result : wr_val;
      fin_wr  = commit && (err == ST_RUNNING) && (wr_en || state_ff == S_WAIT);

      if (err != ST_RUNNING) begin
         fin_pc = pc_ff;
         fin_st = err;
      end else begin
         fin_pc = nxt;
         fin_st = (nxt >= limit) ? ST_OFF_END : ST_RUNNING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         len_ff       <= PC_W'(PROG_DEPTH);
         halt_ff      <= ST_RUNNING;
         eq_ff        <= 1'b0;
         lt_ff        <= 1'b0;
         gt_ff        <= 1'b0;
         depth_ff     <= '0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) len_ff <= csr_wdata;
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_READ;
            S_READ: state_ff <= S_EXEC;
            S_EXEC: begin
               if (exec_md) state_ff <= S_WAIT;
               else if (commit) state_ff <= S_IDLE;
            end
            S_WAIT: if (commit) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= fin_pc;
            halt_ff      <= fin_st;
            if (fin_wr) written_ff[REG_W'(req_ff.first_reg)] <= 1'b1;
            if (err == ST_RUNNING) begin
               if (set_flags) begin
                  eq_ff <= (op_a == op_b);
                  lt_ff <= ($signed(op_a) < $signed(op_b));
                  gt_ff <= ($signed(op_a) > $signed(op_b));
               end
               if (push) depth_ff <= depth_ff + 1'b1;
               if (pop) depth_ff <= depth_ff - 1'b1;
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
      if (commit) begin
         rsp_ff.next_pc   <= fin_pc;
         rsp_ff.status    <= fin_st;
         rsp_ff.msg_valid <= mv && (err == ST_RUNNING) && (state_ff == S_EXEC);
         rsp_ff.msg_value <= (mv && (err == ST_RUNNING) && (state_ff == S_EXEC)) ?
                             32'(op_a) : 32'sd0;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

>>> rtl/rtmx_checker.sv
`default_nettype none
module rtmx_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire rtmx_pkg::rsp_type rsp_data
);
   import rtmx_pkg::*;

   logic       halted_ff;
   logic [2:0] last_st_ff;
   logic       rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff <= 1'b0;
      end else if (rsp_take && !halted_ff && rsp_data.status != ST_RUNNING) begin
         halted_ff <= 1'b1;
      end
      if (rsp_take && !halted_ff) last_st_ff <= rsp_data.status;
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_take && halted_ff |-> rsp_data.status == last_st_ff && !rsp_data.msg_valid)
      else $error("halted machine changed status");

   a_msg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.msg_valid |-> rsp_data.msg_value == 32'sd0)
      else $error("message value without message");

   a_msg_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.msg_valid |->
         rsp_data.status == ST_RUNNING || rsp_data.status == ST_OFF_END)
      else $error("message on a halting instruction");
endmodule

bind toy_register_machine_execute_unit rtmx_checker u_rtmx_checker (.*);
`default_nettype wire
